@@ rtl/ibt_pkg.sv @@
// Shared constants, types and the microcode table of the tree traversal block.
`timescale 1ns / 1ps
package ibt_pkg;

   // Tree storage
   localparam int MAX_NODES   = 64;
   localparam int ADDR_W      = 6;
   localparam int COUNT_W     = 7;
   localparam int STACK_DEPTH = 7;
   localparam int DEPTH_W     = 3;

   // Traversal order register codes
   localparam logic [1:0] ORDER_PRE  = 2'd0;
   localparam logic [1:0] ORDER_IN   = 2'd1;
   localparam logic [1:0] ORDER_POST = 2'd2;
   localparam logic [1:0] ORDER_BFS  = 2'd3;

   // Frame phase at which a frame is popped
   localparam logic [1:0] PHASE_LAST = 2'd2;

   // Microprogram step addresses
   typedef enum logic [2:0] {
      STEP_LOAD     = 3'd0,
      STEP_DISPATCH = 3'd1,
      STEP_DFS_INIT = 3'd2,
      STEP_DFS_WALK = 3'd3,
      STEP_BFS_INIT = 3'd4,
      STEP_BFS_WALK = 3'd5,
      STEP_FINISH   = 3'd6
   } step_type;

   // Datapath operation selected by a control word
   typedef enum logic [2:0] {
      OP_NOP      = 3'd0,
      OP_LOAD     = 3'd1,
      OP_DFS_INIT = 3'd2,
      OP_DFS_STEP = 3'd3,
      OP_BFS_INIT = 3'd4,
      OP_BFS_STEP = 3'd5,
      OP_CLEAR    = 3'd6
   } op_type;

   // Jump conditions
   typedef enum logic [1:0] {
      COND_ALWAYS   = 2'd0,
      COND_LAST_IN  = 2'd1,
      COND_ORDER_BF = 2'd2,
      COND_DONE     = 2'd3
   } cond_type;

   // What the step counter does when the jump is not taken
   typedef enum logic {
      MISS_STAY = 1'b0,
      MISS_NEXT = 1'b1
   } miss_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      miss_type miss;
   } ucode_word_type;

   // Control store
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type word;
      word = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD, miss: MISS_STAY};
      case (step)
         STEP_LOAD:
            word = '{op: OP_LOAD, cond: COND_LAST_IN, target: STEP_DISPATCH,
                     miss: MISS_STAY};
         STEP_DISPATCH:
            word = '{op: OP_NOP, cond: COND_ORDER_BF, target: STEP_BFS_INIT,
                     miss: MISS_NEXT};
         STEP_DFS_INIT:
            word = '{op: OP_DFS_INIT, cond: COND_ALWAYS, target: STEP_DFS_WALK,
                     miss: MISS_NEXT};
         STEP_DFS_WALK:
            word = '{op: OP_DFS_STEP, cond: COND_DONE, target: STEP_FINISH,
                     miss: MISS_STAY};
         STEP_BFS_INIT:
            word = '{op: OP_BFS_INIT, cond: COND_ALWAYS, target: STEP_BFS_WALK,
                     miss: MISS_NEXT};
         STEP_BFS_WALK:
            word = '{op: OP_BFS_STEP, cond: COND_DONE, target: STEP_FINISH,
                     miss: MISS_STAY};
         STEP_FINISH:
            word = '{op: OP_CLEAR, cond: COND_ALWAYS, target: STEP_LOAD,
                     miss: MISS_STAY};
         default:
            word = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD, miss: MISS_STAY};
      endcase
      return word;
   endfunction

endpackage

@@ rtl/implicit_binary_tree_traversal.sv @@
// Array-form binary tree loader and traversal emitter with a microcoded sequencer.
`timescale 1ns / 1ps
// Usage:
//   req_ channel: one node value per transaction, in array order (children of
//   node i sit at 2i+1 and 2i+2). Loads take one transaction per cycle.
//   req_last_node marks the final node; it is stored, then the walk starts.
//   Nodes beyond 64 are dropped and every result of that walk shows
//   rsp_overflowed.
//   rsp_ channel: one transaction per stored node in the order set by the
//   csr_ register (0 preorder, 1 inorder, 2 postorder, 3 index order);
//   rsp_last_out marks the final one. csr_ must be written only while idle;
//   the block itself does not enforce it. After the last node, two sequencer
//   steps set up the walk. Unless rsp_ stalls, index order then gives one
//   result per cycle and the depth-first walk visits each node three times
//   on a one-frame-per-cycle stack. One finish step clears the tree, then
//   loading resumes. req_stall is high for the whole walk. A stalled rsp_
//   holds its result and freezes the walk; the output register lets the walk
//   run one step ahead. Reset (synchronous) empties the tree, selects preorder
//   and idles the output; the node store itself is not cleared.
module implicit_binary_tree_traversal (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_node_value,
   input  logic        req_last_node,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_value,
   output logic [5:0]  rsp_out_index,
   output logic        rsp_last_out,
   output logic        rsp_overflowed,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);
   import ibt_pkg::*;

   // Sequencer
   step_type       step_ff, step_in;
   ucode_word_type uword;
   logic           cond_hit;

   // Datapath registers
   logic [31:0]        tree_mem [MAX_NODES];
   logic [31:0]        rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic [COUNT_W-1:0] node_count_ff, node_count_in;
   logic               overflow_ff, overflow_in;
   logic [1:0]         order_ff;
   logic [COUNT_W-1:0] emit_count_ff, emit_count_in;

   // Walk stack: top frame in registers, the rest in a small array
   logic [ADDR_W-1:0]  top_pos_ff, top_pos_in;
   logic [1:0]         top_phase_ff, top_phase_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [ADDR_W-1:0]  saved_pos_ff [STACK_DEPTH];
   logic [1:0]         saved_phase_ff [STACK_DEPTH];
   logic               push_en;
   logic [DEPTH_W-1:0] push_idx, pop_idx;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_value_ff, out_value_in;
   logic [5:0]  out_index_ff, out_index_in;
   logic        last_out_ff, last_out_in;
   logic        overflowed_ff, overflowed_in;

   logic               req_take, out_free, advance, emit, walk_done;
   logic [ADDR_W-1:0]  emit_pos;
   logic [ADDR_W+1:0]  child_pos;
   logic [COUNT_W-1:0] emit_next;

   assign uword     = ucode_rom(step_ff);
   assign req_stall = (uword.op != OP_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign child_pos = {1'b0, top_pos_ff, 1'b1} + {{ADDR_W{1'b0}}, top_phase_ff};
   assign emit_next = emit_count_ff + 1'b1;
   assign push_idx  = depth_ff - 1'b1;
   assign pop_idx   = depth_ff - 2'd2;

   // Datapath control for the current microcode operation
   always_comb begin
      node_count_in = node_count_ff;
      overflow_in   = overflow_ff;
      emit_count_in = emit_count_ff;
      top_pos_in    = top_pos_ff;
      top_phase_in  = top_phase_ff;
      depth_in      = depth_ff;
      push_en       = 1'b0;
      rd_addr       = top_pos_ff;
      emit          = 1'b0;
      advance       = 1'b0;
      walk_done     = 1'b0;
      emit_pos      = top_pos_ff;
      case (uword.op)
         OP_LOAD: begin
            if (req_take) begin
               if (node_count_ff < COUNT_W'(MAX_NODES)) begin
                  node_count_in = node_count_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         OP_DFS_INIT: begin
            top_pos_in    = '0;
            top_phase_in  = ORDER_PRE;
            depth_in      = DEPTH_W'(1);
            emit_count_in = '0;
            rd_addr       = '0;
         end
         OP_DFS_STEP: begin
            emit     = (top_phase_ff == order_ff);
            advance  = !emit || out_free;
            emit_pos = top_pos_ff;
            if (advance) begin
               if (emit) begin
                  emit_count_in = emit_next;
               end
               if (top_phase_ff == PHASE_LAST) begin
                  // pop: resume parent frame, or finish at the root
                  if (depth_ff == DEPTH_W'(1)) begin
                     walk_done = 1'b1;
                     depth_in  = '0;
                  end else begin
                     top_pos_in   = saved_pos_ff[pop_idx];
                     top_phase_in = saved_phase_ff[pop_idx];
                     depth_in     = depth_ff - 1'b1;
                  end
               end else if (child_pos < {1'b0, node_count_ff}) begin
                  // descend into the child of this phase
                  push_en      = 1'b1;
                  top_pos_in   = child_pos[ADDR_W-1:0];
                  top_phase_in = ORDER_PRE;
                  depth_in     = depth_ff + 1'b1;
               end else begin
                  top_phase_in = top_phase_ff + 1'b1;
               end
               rd_addr = top_pos_in;
            end
         end
         OP_BFS_INIT: begin
            emit_count_in = '0;
            rd_addr       = '0;
         end
         OP_BFS_STEP: begin
            emit     = 1'b1;
            advance  = out_free;
            emit_pos = emit_count_ff[ADDR_W-1:0];
            rd_addr  = emit_count_ff[ADDR_W-1:0];
            if (advance) begin
               emit_count_in = emit_next;
               rd_addr       = emit_next[ADDR_W-1:0];
               walk_done     = (emit_next == node_count_ff);
            end
         end
         OP_CLEAR: begin
            node_count_in = '0;
            overflow_in   = 1'b0;
            depth_in      = '0;
         end
         default: begin
            rd_addr = top_pos_ff;
         end
      endcase
   end

   // Output register load and drain
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_value_in  = out_value_ff;
      out_index_in  = out_index_ff;
      last_out_in   = last_out_ff;
      overflowed_in = overflowed_ff;
      if (emit && advance) begin
         rsp_valid_in  = 1'b1;
         out_value_in  = rd_data_ff;
         out_index_in  = emit_pos;
         last_out_in   = (emit_next == node_count_ff);
         overflowed_in = overflow_ff;
      end
   end

   // Sequencer next step
   always_comb begin
      case (uword.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_LAST_IN:  cond_hit = req_take && req_last_node;
         COND_ORDER_BF: cond_hit = (order_ff == ORDER_BFS);
         COND_DONE:     cond_hit = walk_done;
         default:       cond_hit = 1'b0;
      endcase
      if (cond_hit) begin
         step_in = uword.target;
      end else if (uword.miss == MISS_NEXT) begin
         step_in = step_type'(step_ff + 3'd1);
      end else begin
         step_in = step_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_LOAD;
         node_count_ff <= '0;
         overflow_ff   <= 1'b0;
         order_ff      <= ORDER_PRE;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         node_count_ff <= node_count_in;
         overflow_ff   <= overflow_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            order_ff <= csr_write_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      emit_count_ff <= emit_count_in;
      top_pos_ff    <= top_pos_in;
      top_phase_ff  <= top_phase_in;
      out_value_ff  <= out_value_in;
      out_index_ff  <= out_index_in;
      last_out_ff   <= last_out_in;
      overflowed_ff <= overflowed_in;
      if (push_en) begin
         saved_pos_ff[push_idx]   <= top_pos_ff;
         saved_phase_ff[push_idx] <= top_phase_ff + 1'b1;
      end
   end

   // Node store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (uword.op == OP_LOAD && req_take && node_count_ff < COUNT_W'(MAX_NODES)) begin
         tree_mem[node_count_ff[ADDR_W-1:0]] <= req_node_value;
      end
      rd_data_ff <= tree_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = out_value_ff;
   assign rsp_out_index  = out_index_ff;
   assign rsp_last_out   = last_out_ff;
   assign rsp_overflowed = overflowed_ff;

endmodule

@@ bench/ibt_traversal_checker.sv @@
// Checker for the tree traversal block: predicts every walk and compares results.
`timescale 1ns / 1ps
module ibt_traversal_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_node_value,
   input  logic        req_last_node,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_out_value,
   input  logic [5:0]  rsp_out_index,
   input  logic        rsp_last_out,
   input  logic        rsp_overflowed,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   output int          mismatch_count,
   output int          backlog,
   output int          results_checked
);
   import ibt_pkg::*;

   // One expected result transaction
   typedef struct {
      logic signed [31:0] value;
      logic [ADDR_W-1:0]  index;
      logic               last;
      logic               overflowed;
   } visit_type;

   visit_type          pending_visits[$];
   logic signed [31:0] node_values [MAX_NODES];
   int                 nodes_held;
   logic               dropped_any;
   logic [1:0]         walk_order;

   function automatic void queue_visit(input int pos);
      visit_type v;
      v.value      = node_values[pos];
      v.index      = ADDR_W'(pos);
      v.last       = 1'b0;
      v.overflowed = dropped_any;
      pending_visits.push_back(v);
   endfunction

   // Expected visit sequence for the tree held now, in the selected order
   function automatic void predict_walk();
      int         frame_node [8];
      logic [1:0] frame_phase [8];
      int         depth;
      int         pos;
      int         child;
      logic [1:0] phase;
      if (walk_order == ORDER_BFS) begin
         for (int i = 0; i < nodes_held; i++)
            queue_visit(i);
      end else begin
         depth          = 1;
         frame_node[0]  = 0;
         frame_phase[0] = 2'd0;
         while (depth > 0) begin
            pos   = frame_node[depth-1];
            phase = frame_phase[depth-1];
            // phase 0/1/2 = before left, between children, after right
            if (phase == walk_order)
               queue_visit(pos);
            if (phase == PHASE_LAST) begin
               depth--;
            end else begin
               frame_phase[depth-1] = phase + 2'd1;
               child = 2 * pos + 1 + int'(phase);
               if (child < nodes_held) begin
                  frame_node[depth]  = child;
                  frame_phase[depth] = 2'd0;
                  depth++;
               end
            end
         end
      end
      pending_visits[pending_visits.size()-1].last = 1'b1;
   endfunction

   // Sample both channels and the register port at each rising edge
   always @(posedge clock) begin
      visit_type want;
      if (reset) begin
         pending_visits.delete();
         nodes_held      = 0;
         dropped_any     = 1'b0;
         walk_order      = ORDER_PRE;
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (csr_write_enable)
            walk_order = csr_write_data;

         // result side first: nothing accepted now can answer this edge's input
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (pending_visits.size() == 0) begin
               $error("unexpected result transaction: out_value %0d out_index %0d",
                      $signed(rsp_out_value), rsp_out_index);
               mismatch_count++;
            end else begin
               want = pending_visits.pop_front();
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %0d, got %0d", want.value,
                         $signed(rsp_out_value));
                  mismatch_count++;
               end
               if (rsp_out_index !== want.index) begin
                  $error("out_index: expected %0d, got %0d", want.index, rsp_out_index);
                  mismatch_count++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out: expected %0b, got %0b", want.last, rsp_last_out);
                  mismatch_count++;
               end
               if (rsp_overflowed !== want.overflowed) begin
                  $error("overflowed: expected %0b, got %0b", want.overflowed,
                         rsp_overflowed);
                  mismatch_count++;
               end
            end
         end

         // load side: store or drop, then walk on the final node
         if (req_valid && !req_stall) begin
            if (nodes_held < MAX_NODES) begin
               node_values[nodes_held] = req_node_value;
               nodes_held++;
            end else begin
               dropped_any = 1'b1;
            end
            if (req_last_node) begin
               predict_walk();
               nodes_held  = 0;
               dropped_any = 1'b0;
            end
         end
      end
      backlog = pending_visits.size();
   end

endmodule

@@ bench/implicit_binary_tree_traversal_test.sv @@
// Testbench top for the tree traversal block: stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module implicit_binary_tree_traversal_test;
   import ibt_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_NODES   = 75;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_node_value;
   logic        req_last_node;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_out_value;
   logic [5:0]  rsp_out_index;
   logic        rsp_last_out;
   logic        rsp_overflowed;
   logic        csr_write_enable;
   logic [1:0]  csr_write_data;

   int mismatch_count;
   int backlog;
   int results_checked;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_wanted   = 1'b0;
   int nodes_sent    = 0;
   int trees_loaded  = 0;
   int overflow_trees = 0;
   int cycle_count;

   implicit_binary_tree_traversal dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_node_value   (req_node_value),
      .req_last_node    (req_last_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_index    (rsp_out_index),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflowed   (rsp_overflowed),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ibt_traversal_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_node_value   (req_node_value),
      .req_last_node    (req_last_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_index    (rsp_out_index),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflowed   (rsp_overflowed),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .backlog          (backlog),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out after %0d cycles, %0d results still due", cycle_count, backlog);
      $display("[implicit_binary_tree_traversal] ERROR");
      $finish;
   end

   // Result side: random stalls, plus one long hold on request
   initial begin
      int hold_left;
      bit hold_armed;
      hold_left  = 0;
      hold_armed = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_armed) begin
            hold_armed = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (!hold_wanted)
            hold_armed = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic logic [31:0] corner_value(input int idx);
      case (idx % 6)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         default: return 32'h5555_5555;
      endcase
   endfunction

   // Mostly full-range random values, now and then an extreme
   function automatic logic [31:0] node_value_pick();
      if ($urandom_range(0, 7) == 0)
         return corner_value($urandom_range(0, 5));
      return $urandom;
   endfunction

   // One input transaction, with random idle cycles ahead of it
   task automatic send_node(input logic [31:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_node_value <= value;
      req_last_node  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      nodes_sent++;
   endtask

   task automatic load_tree(input int size, input bit corners);
      for (int i = 0; i < size; i++)
         send_node(corners ? corner_value(i) : node_value_pick(), i == size - 1);
      trees_loaded++;
      if (size > MAX_NODES)
         overflow_trees++;
   endtask

   // Stop offering, let every result drain and the walk wind down
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_order(input logic [1:0] order);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= order;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Stimulus and verdict
   initial begin
      int size;
      int phase_start;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_node_value   <= '0;
      req_last_node    <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= ORDER_PRE;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: preorder comes from reset, then every order on corner values
      load_tree(1, 1'b1);
      load_tree(6, 1'b1);
      set_order(ORDER_IN);
      load_tree(6, 1'b1);
      set_order(ORDER_POST);
      load_tree(6, 1'b1);
      set_order(ORDER_BFS);
      load_tree(5, 1'b1);

      // capacity: past full (last node dropped too), then exactly full
      set_order(ORDER_IN);
      load_tree(MAX_NODES + 3, 1'b0);
      load_tree(MAX_NODES, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         // long output hold while the next tree keeps knocking
         if (phase == 2) begin
            set_order(ORDER_PRE);
            hold_wanted = 1'b1;
            load_tree(12, 1'b0);
            load_tree(9, 1'b0);
            hold_wanted = 1'b0;
         end

         set_order(2'($urandom_range(ORDER_PRE, ORDER_BFS)));
         phase_start = nodes_sent;
         while (nodes_sent - phase_start < PHASE_NODES) begin
            if ($urandom_range(0, 19) == 0)
               size = $urandom_range(20, MAX_NODES + 6);
            else
               size = $urandom_range(1, 10);
            load_tree(size, 1'b0);
            if ($urandom_range(0, 3) == 0)
               set_order(2'($urandom_range(ORDER_PRE, ORDER_BFS)));
         end
      end

      wait_idle();
      $display("covered %0d node transactions in %0d trees (%0d over capacity), all orders",
               nodes_sent, trees_loaded, overflow_trees);
      $display("compared %0d results under three stall mixes and a %0d-cycle output hold",
               results_checked, LONG_HOLD);
      if (mismatch_count == 0 && backlog == 0)
         $display("[implicit_binary_tree_traversal] OK");
      else
         $display("[implicit_binary_tree_traversal] ERROR");
      $finish;
   end

endmodule
